[src/tcds_pkg.sv]
// ----------------------------------------------------------------------------
// tcds_pkg
// Shared types and constants for the tunnel centering drive step block.
// ----------------------------------------------------------------------------
`default_nettype none
package tcds_pkg;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned STEP_W    = 15;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DIST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_MARGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_LIMIT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP     = 3'd7;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_DRIVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL, ST_DONE
  } tcds_state_t;

  // start, busy and done signals of the serial divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } tcds_div_ctl_t;

endpackage
`default_nettype wire

[src/tcds_stream_if.sv]
// ----------------------------------------------------------------------------
// tcds_stream_if
// Valid/ready channel carrying a payload of parameterised width.
// ----------------------------------------------------------------------------
`default_nettype none
interface tcds_stream_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/tcds_divider.sv]
// ----------------------------------------------------------------------------
// tcds_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tcds_divider #(
  parameter int unsigned NW = 44,
  parameter int unsigned DW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [NW-1:0]        numer,
  input  wire logic [DW-1:0]        denom,
  output logic                      done,
  output logic [NW-1:0]             quot
);
  import tcds_pkg::*;

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt    = numer;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= denom;
  end

  assign done = busy_r && (cnt_r == CW'(1));
  assign quot = q_nxt;
endmodule
`default_nettype wire

[src/tunnel_centering_drive_step_top.sv]
// ----------------------------------------------------------------------------
// tunnel_centering_drive_step_top
// PD wall-centering controller: start / tick / stop requests, drive steps out.
// ----------------------------------------------------------------------------
// Each request yields exactly one result. Start, stop, unused opcodes, ticks
// outside auto mode and ticks that decide an exit, an obstacle, a skip, a
// missing side, the deadband or a zero or too long time gap put their result
// out the cycle after acceptance. A tick that needs a PD correction runs a
// bit-serial restoring divider for the derivative (one quotient bit a cycle),
// then a serial multiply-accumulate for the P term and one for the D term,
// then clamps the correction and registers the steps. The block holds one
// request at a time; the result sits in an output register and the next
// request is taken once it has been taken.
`default_nettype none
module tunnel_centering_drive_step_top #(
  parameter int unsigned DIST_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [tcds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcds_pkg::CFG_DAT_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [DIST_WIDTH-1:0]         in_dist_front,
  input  wire logic [DIST_WIDTH-1:0]         in_dist_left,
  input  wire logic [DIST_WIDTH-1:0]         in_dist_back,
  input  wire logic [DIST_WIDTH-1:0]         in_dist_right,
  input  wire logic [3:0]                    in_timeout_mask,
  input  wire logic [31:0]                   in_now_ms,
  input  wire logic                          in_wheels_settled,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_action,
  output logic signed [tcds_pkg::STEP_W-1:0] out_left_step,
  output logic signed [tcds_pkg::STEP_W-1:0] out_right_step,
  output logic                               out_exited_flag,
  output logic                               out_moving_flag,
  output logic                               out_tunnel_flag,
  output logic                               out_auto_flag
);
  import tcds_pkg::*;

  localparam int unsigned EW  = DIST_WIDTH + 1;      // signed error
  localparam int unsigned NW  = DIST_WIDTH + 11;     // |diff|*1000 magnitude
  localparam int unsigned AW  = DIST_WIDTH + 30;     // accumulator
  localparam int unsigned MCW = $clog2(NW + 1);
  // compare width: a distance against a 16-bit register, sums included
  localparam int unsigned XW  = ((DIST_WIDTH > 16) ? DIST_WIDTH : 16) + 1;

  // configuration registers
  logic [15:0] gain_p_r, gain_d_r, stop_r, dead_r, margin_r, gap_r;
  logic [12:0] base_r;
  logic [11:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= 16'd1966; gain_d_r <= 16'd328; stop_r <= 16'd240;
      dead_r   <= 16'd32;   margin_r <= 16'd320; base_r <= 13'd1229;
      lim_r    <= 12'd410;  gap_r    <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_PROP:   gain_p_r <= cfg_data;
        REG_GAIN_DERIV:  gain_d_r <= cfg_data;
        REG_STOP_DIST:   stop_r   <= cfg_data;
        REG_DEADBAND:    dead_r   <= cfg_data;
        REG_EXIT_MARGIN: margin_r <= cfg_data;
        REG_BASE_STEP:   base_r   <= cfg_data[12:0];
        REG_CORR_LIMIT:  lim_r    <= cfg_data[11:0];
        REG_MAX_GAP:     gap_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // block state
  logic auto_r, pend_r, tun_r, exit_r;
  logic [DIST_WIDTH-1:0] base_rd_r [4];
  logic signed [EW-1:0] perr_r;
  logic [31:0] ptime_r;

  tcds_state_t st_r, st_nxt;

  // PD working registers
  logic signed [EW-1:0] err_r;
  logic                 dneg_r;
  logic [NW-1:0]        dmag_r;     // |derivative|, then shifted during mul
  logic signed [AW-1:0] mcand_r;    // gain, shifted up one place a cycle
  logic signed [AW-1:0] acc_r;
  logic [EW-1:0]        emag_r;
  logic                 phase_r;    // 0: P term, 1: D term
  logic [MCW-1:0]       mcnt_r;

  // output register
  logic [1:0] act_r;
  logic signed [STEP_W-1:0] ls_r, rs_r;
  logic ov_r;

  // divider
  logic          div_start, div_done;
  logic [NW-1:0] div_q;
  logic [NW-1:0] div_num;
  logic [31:0]   dt;

  tcds_divider #(.NW(NW), .DW(32)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .numer(div_num),
    .denom(dt), .done(div_done), .quot(div_q)
  );

  // combinational decision for an accepted request
  logic [DIST_WIDTH-1:0] d [4];
  logic [3:0] vld;
  logic [2:0] cnt;
  logic signed [EW-1:0] err;
  logic [EW-1:0] emag;
  logic signed [EW:0] ediff;
  logic [EW:0] edmag;
  logic fire;
  logic exit_hit, stop_hit, pend_eff, dead_hit;

  assign d[0] = in_dist_front; assign d[1] = in_dist_left;
  assign d[2] = in_dist_back;  assign d[3] = in_dist_right;
  assign dt   = in_now_ms - ptime_r;
  assign in_ready = (st_r == ST_IDLE) && !ov_r;
  assign fire = in_valid && in_ready;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < 4; i++) begin
      vld[i] = !in_timeout_mask[i] && (d[i] != '0);
      if (tun_r && base_rd_r[i] != '0 && vld[i] &&
          (XW'(d[i]) > (XW'(base_rd_r[i]) + XW'(margin_r))))
        cnt = cnt + 3'd1;
    end
    err   = $signed({1'b0, in_dist_right}) - $signed({1'b0, in_dist_left});
    emag  = err[EW-1] ? EW'(-err) : EW'(err);
    ediff = $signed({err[EW-1], err}) - $signed({perr_r[EW-1], perr_r});
    edmag = ediff[EW] ? (EW+1)'(-ediff) : (EW+1)'(ediff);
    // |diff|*1000 = (x<<10) - (x<<4) - (x<<3)
    div_num = (NW'(edmag) << 10) - (NW'(edmag) << 4) - (NW'(edmag) << 3);
    exit_hit = cnt >= 3'd2;
    stop_hit = (vld[0] && XW'(d[0]) < XW'(stop_r)) ||
               (vld[2] && XW'(d[2]) < XW'(stop_r));
    pend_eff = pend_r && !in_wheels_settled;   // still moving after this tick
    dead_hit = XW'(emag) < XW'(dead_r);
  end

  // clamp of final correction
  logic signed [AW-1:0] corr_f;
  logic signed [AW-1:0] corr_c;
  logic signed [AW-1:0] limx;
  always_comb begin
    corr_f = acc_r >>> 8;
    limx   = AW'(lim_r);
    if (corr_f > limx) corr_c = limx;
    else if (corr_f < -limx) corr_c = -limx;
    else corr_c = corr_f;
  end

  logic pd_go;
  logic [31:0] gapx;
  assign gapx = {16'd0, gap_r};

  always_comb begin
    st_nxt    = st_r;
    div_start = 1'b0;
    pd_go     = 1'b0;
    case (st_r)
      ST_IDLE: if (fire && in_opcode == OP_TICK && auto_r && !exit_hit && !stop_hit &&
                   !pend_eff && vld[1] && vld[3] && !dead_hit &&
                   dt != 32'd0 && dt <= gapx) begin
        pd_go     = 1'b1;
        div_start = 1'b1;
        st_nxt    = ST_DIV;
      end
      ST_DIV:  if (div_done) st_nxt = ST_MUL;
      ST_MUL:  if (phase_r && mcnt_r == MCW'(1)) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  // note: P uses emag bits, D uses dmag bits; sign applied per term
  logic cur_bit;
  logic cur_neg;
  assign cur_bit = phase_r ? dmag_r[0] : emag_r[0];
  assign cur_neg = phase_r ? dneg_r : err_r[EW-1];

  // next controller state and result register
  logic auto_nxt, pend_nxt, tun_nxt, exit_nxt, ov_nxt;
  logic [DIST_WIDTH-1:0] base_rd_nxt [4];
  logic signed [EW-1:0] perr_nxt;
  logic [31:0] ptime_nxt;
  logic [1:0] act_nxt;
  logic signed [STEP_W-1:0] ls_nxt, rs_nxt;

  always_comb begin
    auto_nxt  = auto_r;  pend_nxt  = pend_r; tun_nxt = tun_r; exit_nxt = exit_r;
    perr_nxt  = perr_r;  ptime_nxt = ptime_r;
    act_nxt   = act_r;   ls_nxt    = ls_r;   rs_nxt  = rs_r;  ov_nxt   = ov_r;
    for (int i = 0; i < 4; i++) base_rd_nxt[i] = base_rd_r[i];
    if (out_valid && out_ready) ov_nxt = 1'b0;
    if (fire) begin
      act_nxt = ACT_NONE; ls_nxt = '0; rs_nxt = '0;
      ov_nxt  = !pd_go;
      case (in_opcode)
        OP_START: begin
          auto_nxt = 1'b1; exit_nxt = 1'b0; perr_nxt = '0; ptime_nxt = in_now_ms;
          for (int i = 0; i < 4; i++) base_rd_nxt[i] = vld[i] ? d[i] : '0;
          tun_nxt = vld[1] && vld[3];
        end
        OP_STOP: begin
          auto_nxt = 1'b0; pend_nxt = 1'b0; act_nxt = ACT_STOP;
        end
        OP_TICK: begin
          if (in_wheels_settled) pend_nxt = 1'b0;
          if (auto_r) begin
            if (exit_hit) begin
              exit_nxt = 1'b1;
              if (pend_eff) begin
                act_nxt = ACT_STOP; pend_nxt = 1'b0;
              end
            end else if (stop_hit) begin
              if (pend_eff) begin
                act_nxt = ACT_STOP; pend_nxt = 1'b0;
              end
            end else if (!pend_eff && vld[1] && vld[3]) begin
              pend_nxt = 1'b1;
              act_nxt  = ACT_DRIVE;
              if (dead_hit) begin
                ls_nxt = STEP_W'(base_r); rs_nxt = STEP_W'(base_r);
              end else begin
                ptime_nxt = in_now_ms;
                perr_nxt  = err;
                if (!pd_go) begin
                  ls_nxt = STEP_W'(base_r); rs_nxt = STEP_W'(base_r);
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (st_r == ST_DONE) begin
      ls_nxt = STEP_W'($signed({2'b00, base_r}) + corr_c);
      rs_nxt = STEP_W'($signed({2'b00, base_r}) - corr_c);
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r <= 1'b0; pend_r <= 1'b0; tun_r <= 1'b0; exit_r <= 1'b0;
      perr_r <= '0;   ptime_r <= '0;  ov_r <= 1'b0;
      act_r  <= ACT_NONE; ls_r <= '0; rs_r <= '0;
      for (int i = 0; i < 4; i++) base_rd_r[i] <= '0;
    end else begin
      auto_r <= auto_nxt; pend_r <= pend_nxt; tun_r <= tun_nxt; exit_r <= exit_nxt;
      perr_r <= perr_nxt; ptime_r <= ptime_nxt; ov_r <= ov_nxt;
      act_r  <= act_nxt;  ls_r <= ls_nxt; rs_r <= rs_nxt;
      for (int i = 0; i < 4; i++) base_rd_r[i] <= base_rd_nxt[i];
    end
  end

  // PD datapath, payload only
  always_ff @(posedge clk) begin
    if (pd_go) begin
      err_r  <= err;
      emag_r <= emag;
      dneg_r <= ediff[EW];
      acc_r  <= '0;
    end else if (st_r == ST_DIV) begin
      if (div_done) begin
        dmag_r  <= div_q;
        phase_r <= 1'b0;
        mcnt_r  <= MCW'(EW);
        mcand_r <= AW'(gain_p_r);
      end
    end else if (st_r == ST_MUL) begin
      if (cur_bit) acc_r <= cur_neg ? acc_r - mcand_r : acc_r + mcand_r;
      if (!phase_r) emag_r <= emag_r >> 1;
      else          dmag_r <= dmag_r >> 1;
      if (!phase_r && mcnt_r == MCW'(1)) begin
        phase_r <= 1'b1;
        mcnt_r  <= MCW'(NW);
        mcand_r <= AW'(gain_d_r);
      end else begin
        mcnt_r  <= mcnt_r - 1'b1;
        mcand_r <= mcand_r << 1;
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_action      = act_r;
  assign out_left_step   = ls_r;
  assign out_right_step  = rs_r;
  assign out_exited_flag = exit_r;
  assign out_moving_flag = pend_r;
  assign out_tunnel_flag = tun_r;
  assign out_auto_flag   = auto_r;
endmodule
`default_nettype wire

[test/tunnel_centering_drive_step_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tunnel_centering_drive_step_top_test
// Self-checking bench for the wall-centering drive step block: a directed
// table followed by random navigation sequences under several register
// settings, with bursty requests, a stalling receiver and one long hold-off.
// ----------------------------------------------------------------------------
module tunnel_centering_drive_step_top_test;
  import tcds_pkg::*;

  localparam int DW = 16;

  typedef struct packed {
    logic [1:0]    opcode;
    logic [DW-1:0] front;
    logic [DW-1:0] left;
    logic [DW-1:0] back;
    logic [DW-1:0] right;
    logic [3:0]    tmask;
    logic [31:0]   now_ms;
    logic          settled;
  } nav_req_t;

  localparam int REQ_W = $bits(nav_req_t);

  typedef struct packed {
    logic [1:0]               action;
    logic signed [STEP_W-1:0] left_step;
    logic signed [STEP_W-1:0] right_step;
    logic                     exited;
    logic                     moving;
    logic                     tunnel;
    logic                     auto_flag;
  } drive_res_t;

  typedef struct {
    nav_req_t   req;
    bit         typed;
    drive_res_t res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  tcds_stream_if #(.W($bits(nav_req_t)))   req_ch ();
  tcds_stream_if #(.W($bits(drive_res_t))) res_ch ();

  nav_req_t   req_bus;
  drive_res_t res_bus;
  assign req_bus = nav_req_t'(req_ch.data);
  assign res_ch.data = res_bus;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    res_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  tunnel_centering_drive_step_top #(.DIST_WIDTH(DW)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (req_ch.valid),
    .in_ready          (req_ch.ready),
    .in_opcode         (req_bus.opcode),
    .in_dist_front     (req_bus.front),
    .in_dist_left      (req_bus.left),
    .in_dist_back      (req_bus.back),
    .in_dist_right     (req_bus.right),
    .in_timeout_mask   (req_bus.tmask),
    .in_now_ms         (req_bus.now_ms),
    .in_wheels_settled (req_bus.settled),
    .out_valid         (res_ch.valid),
    .out_ready         (res_ch.ready),
    .out_action        (res_bus.action),
    .out_left_step     (res_bus.left_step),
    .out_right_step    (res_bus.right_step),
    .out_exited_flag   (res_bus.exited),
    .out_moving_flag   (res_bus.moving),
    .out_tunnel_flag   (res_bus.tunnel),
    .out_auto_flag     (res_bus.auto_flag)
  );

  // --------------------------------------------------------------------------
  // Predictor state: registers and controller state, mirrored here
  // --------------------------------------------------------------------------
  logic [15:0] nav_regs [NUM_REGS];
  bit          p_auto, p_moving, p_tunnel, p_exited;
  logic [DW-1:0] p_baseline [4];
  longint      p_prev_err;
  logic [31:0] p_prev_time;

  drive_res_t  expected_steps [$];
  int          fail_count = 0;

  function automatic void nav_state_reset();
    nav_regs[REG_GAIN_PROP]   = 16'd1966;
    nav_regs[REG_GAIN_DERIV]  = 16'd328;
    nav_regs[REG_STOP_DIST]   = 16'd240;
    nav_regs[REG_DEADBAND]    = 16'd32;
    nav_regs[REG_EXIT_MARGIN] = 16'd320;
    nav_regs[REG_BASE_STEP]   = 16'd1229;
    nav_regs[REG_CORR_LIMIT]  = 16'd410;
    nav_regs[REG_MAX_GAP]     = 16'd1000;
    p_auto = 0; p_moving = 0; p_tunnel = 0; p_exited = 0;
    foreach (p_baseline[i]) p_baseline[i] = '0;
    p_prev_err  = 0;
    p_prev_time = '0;
  endfunction

  // PD correction in 1/4096 rotation, clamped
  function automatic longint pd_correction(longint err, logic [31:0] now);
    logic [31:0] dt;
    longint deriv, sum, lim;
    dt = now - p_prev_time;
    p_prev_time = now;
    if (dt == 0 || dt > nav_regs[REG_MAX_GAP]) begin
      p_prev_err = err;
      return 0;
    end
    deriv = ((err - p_prev_err) * 1000) / longint'(dt);   // truncates toward zero
    p_prev_err = err;
    sum = longint'(nav_regs[REG_GAIN_PROP]) * err
        + longint'(nav_regs[REG_GAIN_DERIV]) * deriv;
    sum = sum >>> 8;                                        // floor
    lim = longint'(nav_regs[REG_CORR_LIMIT]);
    if (sum > lim) sum = lim;
    if (sum < -lim) sum = -lim;
    return sum;
  endfunction

  function automatic drive_res_t drive_step_predict(nav_req_t r);
    drive_res_t res;
    logic [DW-1:0] d [4];
    bit ok [4];
    int opened;
    longint err, mag, corr, base;
    res = '0;
    d[0] = r.front; d[1] = r.left; d[2] = r.back; d[3] = r.right;
    for (int i = 0; i < 4; i++) ok[i] = !r.tmask[i] && d[i] != 0;
    case (r.opcode)
      OP_START: begin
        p_auto = 1; p_exited = 0; p_prev_err = 0; p_prev_time = r.now_ms;
        for (int i = 0; i < 4; i++) p_baseline[i] = ok[i] ? d[i] : '0;
        p_tunnel = p_baseline[1] != 0 && p_baseline[3] != 0;
      end
      OP_STOP: begin
        p_auto = 0; p_moving = 0;
        res.action = ACT_STOP;
      end
      OP_TICK: begin
        if (r.settled) p_moving = 0;
        if (p_auto) begin
          opened = 0;
          if (p_tunnel)
            for (int i = 0; i < 4; i++)
              if (p_baseline[i] != 0 && ok[i] &&
                  longint'(d[i]) > longint'(p_baseline[i]) + nav_regs[REG_EXIT_MARGIN])
                opened++;
          if (opened >= 2) begin
            if (p_moving) begin
              res.action = ACT_STOP; p_moving = 0;
            end
            p_exited = 1;
          end else if ((ok[0] && d[0] < nav_regs[REG_STOP_DIST]) ||
                       (ok[2] && d[2] < nav_regs[REG_STOP_DIST])) begin
            if (p_moving) begin
              res.action = ACT_STOP; p_moving = 0;
            end
          end else if (!p_moving && ok[1] && ok[3]) begin
            err  = longint'(d[3]) - longint'(d[1]);
            mag  = err < 0 ? -err : err;
            base = longint'(nav_regs[REG_BASE_STEP]);
            corr = (mag < nav_regs[REG_DEADBAND]) ? 0 : pd_correction(err, r.now_ms);
            res.left_step  = STEP_W'(base + corr);
            res.right_step = STEP_W'(base - corr);
            p_moving = 1;
            res.action = ACT_DRIVE;
          end
        end
      end
      default: ;  // unused opcode: ignored
    endcase
    res.exited = p_exited; res.moving = p_moving;
    res.tunnel = p_tunnel; res.auto_flag = p_auto;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request sender: bursts with random gaps when gaps are enabled
  // --------------------------------------------------------------------------
  bit sender_gaps = 1;
  int burst_left = 0;

  task automatic send_request(nav_req_t r, bit typed, drive_res_t typed_res);
    drive_res_t pred;
    int gap;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 15);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    pred = drive_step_predict(r);
    expected_steps.push_back(typed ? typed_res : pred);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic sender_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: its own stall pattern, one long hold-off to back the block up
  // --------------------------------------------------------------------------
  int rx_mode = 0;      // 0 always ready, 1 random, 2 bursty pattern
  int rx_cycles = 0;

  initial begin
    int run_len;
    bit level;
    run_len = 0;
    level = 1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles >= 3000 && rx_cycles < 3600) begin
        res_ch.ready <= 1'b0;           // long hold-off while requests keep coming
      end else begin
        case (rx_mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 2) != 0);
          default: begin
            if (run_len == 0) begin
              level = !level;
              run_len = level ? $urandom_range(1, 8) : $urandom_range(1, 25);
            end
            run_len--;
            res_ch.ready <= level;
          end
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    drive_res_t exp_res;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_steps.size() == 0) begin
        $error("result with nothing expected: %p", res_bus);
        fail_count++;
      end else begin
        exp_res = expected_steps.pop_front();
        if (res_bus.action !== exp_res.action) begin
          $error("action: expected %0d, got %0d", exp_res.action, res_bus.action);
          fail_count++;
        end
        if (res_bus.left_step !== exp_res.left_step) begin
          $error("left_step: expected %0d, got %0d", exp_res.left_step, res_bus.left_step);
          fail_count++;
        end
        if (res_bus.right_step !== exp_res.right_step) begin
          $error("right_step: expected %0d, got %0d", exp_res.right_step,
                 res_bus.right_step);
          fail_count++;
        end
        if (res_bus.exited !== exp_res.exited) begin
          $error("exited_flag: expected %0d, got %0d", exp_res.exited, res_bus.exited);
          fail_count++;
        end
        if (res_bus.moving !== exp_res.moving) begin
          $error("moving_flag: expected %0d, got %0d", exp_res.moving, res_bus.moving);
          fail_count++;
        end
        if (res_bus.tunnel !== exp_res.tunnel) begin
          $error("tunnel_flag: expected %0d, got %0d", exp_res.tunnel, res_bus.tunnel);
          fail_count++;
        end
        if (res_bus.auto_flag !== exp_res.auto_flag) begin
          $error("auto_flag: expected %0d, got %0d", exp_res.auto_flag, res_bus.auto_flag);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register writes: only once the block has drained
  // --------------------------------------------------------------------------
  task automatic drain();
    sender_idle();
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      nav_regs[i] = vals[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random navigation sequences
  // --------------------------------------------------------------------------
  logic [31:0] gen_now = 32'd50;
  int          gen_side = 1000;

  function automatic logic [DW-1:0] clip16(longint v);
    if (v < 0) return '0;
    if (v > 65535) return 16'hFFFF;
    return DW'(v);
  endfunction

  function automatic nav_req_t random_request();
    nav_req_t r;
    int pick, delta;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin             // noise: every field anything
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom});
      return r;
    end
    pick = $urandom_range(0, 99);
    r.opcode = pick < 6 ? OP_START : pick < 10 ? OP_STOP : pick < 12 ? 2'd3 : OP_TICK;
    if (r.opcode == OP_START) gen_side = $urandom_range(500, 3000);
    case ($urandom_range(0, 9))
      0: ;                                                    // same millisecond
      1: gen_now += $urandom_range(nav_regs[REG_MAX_GAP] - 1,
                                   32'(nav_regs[REG_MAX_GAP]) + 2);
      2: gen_now += $urandom;
      default: gen_now += $urandom_range(1, 200);
    endcase
    r.now_ms = gen_now;
    delta = $urandom_range(0, 800) - 400;
    if ($urandom_range(0, 3) == 0) delta = $urandom_range(0, 20) - 10;
    r.left  = clip16(gen_side + delta);
    r.right = clip16(gen_side - delta);
    r.front = DW'($urandom_range(0, 6000));
    r.back  = DW'($urandom_range(0, 6000));
    if ($urandom_range(0, 11) == 0) begin      // tunnel opens up
      r.left  = clip16(longint'(gen_side) + nav_regs[REG_EXIT_MARGIN] +
                       $urandom_range(0, 500));
      r.right = clip16(longint'(gen_side) + nav_regs[REG_EXIT_MARGIN] +
                       $urandom_range(0, 500));
    end
    if ($urandom_range(0, 19) == 0) r.left = '0;
    r.tmask   = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
    r.settled = $urandom_range(0, 2) != 0;
    return r;
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) send_request(random_request(), 0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  function automatic table_row_t row(logic [1:0] op, int f, int l, int b, int r,
                                     logic [3:0] m, logic [31:0] t, bit s);
    table_row_t x;
    x.req = '{op, DW'(f), DW'(l), DW'(b), DW'(r), m, t, s};
    x.typed = 0;
    x.res = '0;
    return x;
  endfunction

  function automatic table_row_t typed_row(table_row_t x, logic [1:0] act, int ls,
                                           int rs, bit ex, bit mv, bit tn, bit au);
    x.typed = 1;
    x.res = '{act, STEP_W'(ls), STEP_W'(rs), ex, mv, tn, au};
    return x;
  endfunction

  table_row_t directed [$];

  initial begin
    logic [15:0] cfg_vals [NUM_REGS];

    // after reset: no driving until a start; a stop still answers ACT_STOP
    directed.push_back(typed_row(row(OP_TICK, 5000, 1000, 5000, 1000, 0, 10, 1),
                                 ACT_NONE, 0, 0, 0, 0, 0, 0));
    directed.push_back(typed_row(row(OP_STOP, 0, 0, 0, 0, 0, 11, 0),
                                 ACT_STOP, 0, 0, 0, 0, 0, 0));
    directed.push_back(typed_row(row(2'd3, 65535, 65535, 65535, 65535, 15, 12, 1),
                                 ACT_NONE, 0, 0, 0, 0, 0, 0));
    directed.push_back(typed_row(row(OP_START, 5000, 1000, 5000, 1000, 0, 100, 0),
                                 ACT_NONE, 0, 0, 0, 0, 1, 1));
    // centred: drive straight at the default base step
    directed.push_back(typed_row(row(OP_TICK, 5000, 1000, 5000, 1000, 0, 110, 1),
                                 ACT_DRIVE, 1229, 1229, 0, 1, 1, 1));
    // motion still pending: centering skipped
    directed.push_back(typed_row(row(OP_TICK, 5000, 1000, 5000, 1400, 0, 115, 0),
                                 ACT_NONE, 0, 0, 0, 1, 1, 1));
    directed.push_back(row(OP_TICK, 5000, 1000, 5000, 1400, 0, 120, 1));   // PD
    directed.push_back(row(OP_TICK, 5000, 1000, 5000, 600, 0, 120, 1));    // zero dt
    directed.push_back(row(OP_TICK, 5000, 1000, 5000, 600, 0, 5000, 1));   // over the gap
    directed.push_back(row(OP_TICK, 100, 1000, 5000, 1000, 0, 5010, 0));   // obstacle, moving
    directed.push_back(row(OP_TICK, 5000, 1000, 100, 1000, 0, 5020, 1));   // obstacle behind
    directed.push_back(row(OP_TICK, 100, 1000, 5000, 1300, 1, 5030, 1));   // front timed out
    directed.push_back(row(OP_TICK, 5000, 2000, 5000, 2000, 0, 5040, 0));  // exit, moving
    directed.push_back(row(OP_TICK, 5000, 2000, 5000, 2000, 0, 5050, 1));  // exit again
    directed.push_back(row(OP_TICK, 65535, 65535, 65535, 65535, 15, 5060, 1));
    directed.push_back(row(OP_START, 0, 0, 0, 0, 0, 5070, 1));             // no tunnel
    directed.push_back(row(OP_TICK, 5000, 0, 5000, 1000, 0, 5080, 1));     // side missing
    directed.push_back(row(OP_START, 65535, 65535, 65535, 65535, 0, 32'hFFFF_FFFF, 1));
    directed.push_back(row(OP_TICK, 65535, 1, 65535, 65535, 0, 0, 1));     // wrap, clamp high
    directed.push_back(row(OP_TICK, 65535, 65535, 65535, 1, 0, 1, 1));     // clamp low
    directed.push_back(row(OP_STOP, 65535, 65535, 65535, 65535, 15, 2, 1));

    nav_state_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset settings, no gaps, receiver always ready
    sender_gaps = 0;
    rx_mode = 0;
    foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].res);
    drain();

    // random registers, bursty sender, random receiver
    sender_gaps = 1;
    rx_mode = 1;
    cfg_vals = '{16'(2000 + $urandom_range(0, 8000)), 16'($urandom_range(0, 4000)),
                 16'($urandom_range(100, 600)), 16'($urandom_range(5, 80)),
                 16'($urandom_range(100, 700)), 16'($urandom_range(200, 3000)),
                 16'($urandom_range(100, 1500)), 16'($urandom_range(100, 400))};
    write_regs(cfg_vals);
    random_phase(400);     // spans the receiver's long hold-off
    drain();

    // upper extremes
    rx_mode = 2;
    cfg_vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd8191,
                 16'd4095, 16'hFFFF};
    write_regs(cfg_vals);
    random_phase(250);
    drain();

    // lower extremes
    sender_gaps = 0;
    cfg_vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1};
    write_regs(cfg_vals);
    random_phase(250);
    drain();

    // mid settings, receiver always ready
    sender_gaps = 1;
    rx_mode = 0;
    cfg_vals = '{16'd1966, 16'd328, 16'd240, 16'd32, 16'd320, 16'd1229, 16'd410, 16'd1000};
    write_regs(cfg_vals);
    random_phase(300);
    drain();

    rx_mode = 2;
    cfg_vals = '{16'($urandom), 16'($urandom), 16'($urandom_range(0, 2000)),
                 16'($urandom_range(0, 500)), 16'($urandom_range(0, 2000)),
                 16'($urandom_range(0, 8191)), 16'($urandom_range(0, 4095)),
                 16'($urandom_range(1, 2000))};
    write_regs(cfg_vals);
    random_phase(330);
    drain();

    repeat (20) @(posedge clk);
    if (expected_steps.size() != 0) begin
      $error("%0d results never arrived", expected_steps.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tunnel_centering_drive_step_top test passed");
    end else begin
      $display("tunnel_centering_drive_step_top test failed");
    end
    $finish;
  end

  // run limit: far above the slowest correct run
  initial begin
    #20ms;
    $display("tunnel_centering_drive_step_top test failed");
    $finish;
  end

endmodule

[files.f]
src/tcds_pkg.sv
src/tcds_stream_if.sv
src/tcds_divider.sv
src/tunnel_centering_drive_step_top.sv
test/tunnel_centering_drive_step_top_test.sv
